@@ hdl/vlos_pkg.sv @@
// Shared types and constants for the voxel line-of-sight block.
// Holds field widths and the command/status bundles between controller and datapath.
// No dependencies.
package vlos_pkg;

  // Field widths of one item
  localparam int XY_W  = 6;
  localparam int Z_W   = 4;
  // Error terms stay within +/- 4 * 63, so ten signed bits suffice
  localparam int ERR_W = 10;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;     // zero one row of the grid, advance the sweep address
    logic load;      // capture the accepted item
    logic setup;     // derive lengths, dominant axis and error terms
    logic rd_voxel;  // read the row of the addressed voxel
    logic wr_voxel;  // write back the row with the voxel bit updated
    logic walk;      // issue one read, test the last one, step the line
    logic emit;      // load the result register
  } vlos_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // sweep is at the last row
    logic is_query;   // loaded item is a line query
    logic walk_done;  // occupied voxel found, or every voxel tested
  } vlos_sts_t;

endpackage

@@ hdl/vlos_if.sv @@
// Valid/ready channel interfaces for items and results.
// Depends on vlos_pkg for field widths.
interface vlos_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [vlos_pkg::XY_W-1:0] start_x;
  logic [vlos_pkg::XY_W-1:0] start_y;
  logic [vlos_pkg::Z_W-1:0]  start_z;
  logic [vlos_pkg::XY_W-1:0] end_x;
  logic [vlos_pkg::XY_W-1:0] end_y;
  logic [vlos_pkg::Z_W-1:0]  end_z;
  logic                     occupied;

  modport source (output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  occupied, input ready);
  modport sink   (input valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  occupied, output ready);
endinterface

interface vlos_out_if;
  logic valid;
  logic ready;
  logic was_query;
  logic line_clear;

  modport source (output valid, was_query, line_clear, input ready);
  modport sink   (input valid, was_query, line_clear, output ready);
endinterface

@@ hdl/voxel_line_of_sight.sv @@
// Voxel line-of-sight block: 3D occupancy grid with Bresenham line queries.
// A write reads the addressed row and writes it back with the voxel bit updated; a query
// reads one row per step, L = max(|dx|, |dy|, |dz|) steps, on the single memory port.
// One item is in work at a time; the result register frees the next transfer.
// After reset the grid is swept clear, one row per cycle, GRID_XY * GRID_Z rows
// (1024 by default), before the first item is accepted.
module voxel_line_of_sight #(
  parameter int GRID_XY = 64,
  parameter int GRID_Z  = 16
) (
  input logic       clk,
  input logic       rst_n,
  vlos_in_if.sink   in_ch,
  vlos_out_if.source out_ch
);
  import vlos_pkg::*;

  vlos_cmd_t cmd;
  vlos_sts_t sts;
  logic      in_ready, out_valid, was_query, line_clear;

  vlos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vlos_dp #(
    .GRID_XY (GRID_XY),
    .GRID_Z  (GRID_Z)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_ch.mode),
    .in_start_x     (in_ch.start_x),
    .in_start_y     (in_ch.start_y),
    .in_start_z     (in_ch.start_z),
    .in_end_x       (in_ch.end_x),
    .in_end_y       (in_ch.end_y),
    .in_end_z       (in_ch.end_z),
    .in_occupied    (in_ch.occupied),
    .out_was_query  (was_query),
    .out_line_clear (line_clear)
  );

  // Drive the channel handshakes and result payload
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.was_query  = was_query;
  assign out_ch.line_clear = line_clear;

endmodule

@@ hdl/vlos_ctrl.sv @@
// Controller state machine: clearing sweep, item sequencing and result handshake.
// Depends on vlos_pkg for the command and status bundles.
module vlos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output vlos_pkg::vlos_cmd_t cmd,
  input  vlos_pkg::vlos_sts_t sts
);
  import vlos_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_WR_RD  = 7'b0001000,
    S_WR_WB  = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.is_query ? S_WALK : S_WR_RD;
      end
      S_WR_RD: begin
        cmd.rd_voxel = 1'b1;
        state_nxt    = S_WR_WB;
      end
      S_WR_WB: begin
        cmd.wr_voxel = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/vlos_dp.sv @@
// Datapath: occupancy row memory, Bresenham walk registers and result register.
// Depends on vlos_pkg for widths and the command and status bundles.
module vlos_dp #(
  parameter int GRID_XY = 64,
  parameter int GRID_Z  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vlos_pkg::vlos_cmd_t       cmd,
  output vlos_pkg::vlos_sts_t       sts,
  input  logic                      in_mode,
  input  logic [vlos_pkg::XY_W-1:0] in_start_x,
  input  logic [vlos_pkg::XY_W-1:0] in_start_y,
  input  logic [vlos_pkg::Z_W-1:0]  in_start_z,
  input  logic [vlos_pkg::XY_W-1:0] in_end_x,
  input  logic [vlos_pkg::XY_W-1:0] in_end_y,
  input  logic [vlos_pkg::Z_W-1:0]  in_end_z,
  input  logic                      in_occupied,
  output logic                      out_was_query,
  output logic                      out_line_clear
);
  import vlos_pkg::*;

  localparam int ROWS = GRID_XY * GRID_Z;
  localparam int AW   = $clog2(ROWS);
  localparam int XIW  = $clog2(GRID_XY);

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // One row holds all x of a given (z, y)
  logic [GRID_XY-1:0] mem [ROWS];
  logic [GRID_XY-1:0] rdata_r;
  logic [GRID_XY-1:0] merged;
  logic [AW-1:0]      mem_addr, row_addr, clr_r;
  logic [GRID_XY-1:0] mem_wdata;
  logic               mem_we, mem_re;

  // Captured item
  logic            mode_r, occ_r;
  logic [XY_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [Z_W-1:0]  sz_r, ez_r;

  // Walk state
  logic [XY_W-1:0]         px_r, py_r;
  logic [Z_W-1:0]          pz_r;
  logic                    negx_r, negy_r, negz_r;
  axis_t                   dom_r;
  logic [XY_W-1:0]         ld_r, cnt_r;
  logic [ERR_W-1:0]        la2_r, lb2_r, ld2_r;
  logic signed [ERR_W-1:0] erra_r, errb_r;
  logic                    pend_r, hit_r, rd_ok_r;
  logic [XIW-1:0]          rd_xi_r;
  logic                    was_query_r, line_clear_r;

  // Setup terms
  logic [XY_W-1:0] lx, ly, lz, la, lb, ld;
  axis_t           dom;
  logic            p_ok, issue, step_x, step_y, step_z;

  // Lengths per axis and dominant axis; x wins ties, then y
  always_comb begin
    lx = (ex_r >= sx_r) ? ex_r - sx_r : sx_r - ex_r;
    ly = (ey_r >= sy_r) ? ey_r - sy_r : sy_r - ey_r;
    lz = XY_W'((ez_r >= sz_r) ? ez_r - sz_r : sz_r - ez_r);
    if (lx >= ly && lx >= lz) begin
      dom = AX_X;
      ld  = lx;
      la  = ly;
      lb  = lz;
    end else if (ly >= lz) begin
      dom = AX_Y;
      ld  = ly;
      la  = lx;
      lb  = lz;
    end else begin
      dom = AX_Z;
      ld  = lz;
      la  = ly;
      lb  = lx;
    end
  end

  // Voxel address and grid bounds of the current point
  assign row_addr = AW'(32'(pz_r) * GRID_XY + 32'(py_r));
  assign p_ok     = (32'(px_r) < GRID_XY) && (32'(py_r) < GRID_XY) && (32'(pz_r) < GRID_Z);

  // Step decisions: a is y unless y dominates, b is z unless z dominates
  assign issue  = (cnt_r != ld_r);
  assign step_x = (dom_r == AX_X) || (dom_r == AX_Y && erra_r > 0) ||
                  (dom_r == AX_Z && errb_r > 0);
  assign step_y = (dom_r == AX_Y) || (dom_r != AX_Y && erra_r > 0);
  assign step_z = (dom_r == AX_Z) || (dom_r != AX_Z && errb_r > 0);

  // Row with the addressed voxel replaced
  always_comb begin
    merged          = rdata_r;
    merged[rd_xi_r] = occ_r;
  end

  // Memory port: clearing sweep, voxel read-modify-write, walk reads
  assign mem_addr  = cmd.clear ? clr_r : row_addr;
  assign mem_we    = cmd.clear | (cmd.wr_voxel & p_ok);
  assign mem_re    = cmd.rd_voxel | (cmd.walk & issue);
  assign mem_wdata = cmd.clear ? '0 : merged;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  // Sweep address and walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      pend_r <= cmd.walk & issue;
      if (cmd.setup) begin
        cnt_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.walk) begin
        if (issue) cnt_r <= cnt_r + 1'b1;
        // test the voxel read in the previous cycle
        if (pend_r && rd_ok_r && rdata_r[rd_xi_r]) hit_r <= 1'b1;
      end
    end
  end

  // Item capture, setup and line stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      occ_r  <= in_occupied;
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      sz_r   <= in_start_z;
      ex_r   <= in_end_x;
      ey_r   <= in_end_y;
      ez_r   <= in_end_z;
    end
    if (mem_re) begin
      rd_ok_r <= p_ok;
      rd_xi_r <= XIW'(px_r);
    end
    if (cmd.setup) begin
      px_r   <= sx_r;
      py_r   <= sy_r;
      pz_r   <= sz_r;
      negx_r <= ex_r < sx_r;
      negy_r <= ey_r < sy_r;
      negz_r <= ez_r < sz_r;
      dom_r  <= dom;
      ld_r   <= ld;
      la2_r  <= ERR_W'({la, 1'b0});
      lb2_r  <= ERR_W'({lb, 1'b0});
      ld2_r  <= ERR_W'({ld, 1'b0});
      erra_r <= ERR_W'({la, 1'b0}) - ERR_W'(ld);
      errb_r <= ERR_W'({lb, 1'b0}) - ERR_W'(ld);
    end else if (cmd.walk && issue) begin
      if (step_x) px_r <= negx_r ? px_r - 1'b1 : px_r + 1'b1;
      if (step_y) py_r <= negy_r ? py_r - 1'b1 : py_r + 1'b1;
      if (step_z) pz_r <= negz_r ? pz_r - 1'b1 : pz_r + 1'b1;
      erra_r <= erra_r - ((erra_r > 0) ? ld2_r : '0) + la2_r;
      errb_r <= errb_r - ((errb_r > 0) ? ld2_r : '0) + lb2_r;
    end
    if (cmd.emit) begin
      was_query_r  <= mode_r;
      line_clear_r <= mode_r & ~hit_r;
    end
  end

  // Status to the controller
  assign sts.clr_last  = (clr_r == AW'(ROWS - 1));
  assign sts.is_query  = mode_r;
  assign sts.walk_done = hit_r | (~issue & ~pend_r);

  assign out_was_query  = was_query_r;
  assign out_line_clear = line_clear_r;

endmodule
